// File: rtl/vrp_pkg.sv
// Package with types and constants for the video register port.
`timescale 1ns / 1ps

package vrp_pkg;

    localparam int ATTR_DEPTH = 256;
    localparam int ATTR_AW    = $clog2(ATTR_DEPTH);

    // Register select codes.
    localparam logic [2:0] REG_CTRL      = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
    localparam logic [2:0] REG_OAM_DATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_ADDR      = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    // Command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Video memory access codes.
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    localparam logic [14:0] PALETTE_BASE = 15'h3F00;
    localparam logic [14:0] STEP_ROW     = 15'd32;
    localparam logic [14:0] STEP_ONE     = 15'd1;
    localparam logic [7:0]  OAM_CLEARED  = 8'hFF;

    typedef struct packed {
        logic       command;
        logic [2:0] reg_index;
        logic [7:0] write_value;
        logic [7:0] vram_read_data;
        logic [7:0] vram_mirror_data;
        logic [7:0] status_byte;
        logic       in_vblank;
        logic       oam_clearing;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  vram_access;
        logic [14:0] vram_address;
        logic [7:0]  vram_write_data;
        logic        nmi_request;
        logic        status_read;
        logic [7:0]  control_value;
        logic [7:0]  mask_value;
        logic [14:0] scroll_temp;
        logic [2:0]  fine_scroll_x;
        logic [14:0] render_address;
    } t_rsp;

    // Attribute store port: one write and the read address for the next item.
    typedef struct packed {
        logic               we;
        logic [ATTR_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [ATTR_AW-1:0] raddr;
    } t_attr_req;

endpackage

// File: rtl/vrp_req_if.sv
// Request channel interface of the video register port.
`timescale 1ns / 1ps

interface vrp_req_if;
    logic         valid;
    logic         ready;
    vrp_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/vrp_rsp_if.sv
// Result channel interface of the video register port.
`timescale 1ns / 1ps

interface vrp_rsp_if;
    logic         valid;
    logic         ready;
    vrp_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/video_register_port_core.sv
// Top level of the video register port: register window for processor accesses.
// Path: the request is registered in the input register, then its result in the
//   result register; a stalled result channel holds both until the result is taken.
// Throughput: one access per cycle while results are taken; the state update sets it.
// Reset: synchronous, active low; clears the valid flags, the state registers and the
//   attribute valid bits at once, so the store reads as zero with no clearing pass.
`timescale 1ns / 1ps

module video_register_port_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vrp_req_if.sink         i_req,
    vrp_rsp_if.source       o_rsp
);

    // Input register.
    logic           r_in_vld;
    vrp_pkg::t_req  r_in;

    // Result register.
    logic           r_out_vld;
    vrp_pkg::t_rsp  r_out;

    // Architectural state.
    logic [7:0]                  r_ctrl, n_ctrl;
    logic [7:0]                  r_mask, n_mask;
    logic [vrp_pkg::ATTR_AW-1:0] r_attr_addr, n_attr_addr;
    logic [14:0]                 r_temp, n_temp;
    logic [2:0]                  r_fine_x, n_fine_x;
    logic                        r_toggle, n_toggle;
    logic [14:0]                 r_vaddr, n_vaddr;
    logic [14:0]                 r_bus, n_bus;
    logic [7:0]                  r_buf, n_buf;
    logic [7:0]                  r_open_bus, n_open_bus;

    logic                        process;
    logic                        out_free;
    vrp_pkg::t_rsp               rsp;
    vrp_pkg::t_attr_req          attr_req;
    logic [7:0]                  attr_rdata;
    logic [14:0]                 stepped;
    logic [14:0]                 addr_load;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign process     = r_in_vld && out_free;
    assign i_req.ready = !r_in_vld || process;

    assign stepped   = r_vaddr + (r_ctrl[2] ? vrp_pkg::STEP_ROW : vrp_pkg::STEP_ONE);
    assign addr_load = {1'b0, r_temp[13:8], r_in.write_value};

    always_comb begin
        n_ctrl      = r_ctrl;
        n_mask      = r_mask;
        n_attr_addr = r_attr_addr;
        n_temp      = r_temp;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_vaddr     = r_vaddr;
        n_bus       = r_bus;
        n_buf       = r_buf;
        n_open_bus  = r_open_bus;
        rsp         = '0;
        attr_req.we    = 1'b0;
        attr_req.waddr = r_attr_addr;
        attr_req.wdata = r_in.write_value;

        if (process) begin
            if (r_in.command == vrp_pkg::CMD_READ) begin
                unique case (r_in.reg_index)
                    vrp_pkg::REG_STATUS: begin
                        rsp.read_data   = r_in.status_byte;
                        rsp.status_read = 1'b1;
                        n_toggle        = 1'b0;
                    end
                    vrp_pkg::REG_OAM_DATA: begin
                        rsp.read_data = r_in.oam_clearing ? vrp_pkg::OAM_CLEARED
                                                          : attr_rdata;
                    end
                    vrp_pkg::REG_DATA: begin
                        rsp.vram_address = r_vaddr;
                        rsp.vram_access  = vrp_pkg::ACC_READ;
                        n_vaddr          = stepped;
                        n_bus            = stepped;
                        // Palette reads bypass the delay buffer.
                        if (r_vaddr >= vrp_pkg::PALETTE_BASE) begin
                            rsp.read_data = r_in.vram_read_data;
                            n_buf         = r_in.vram_mirror_data;
                        end else begin
                            rsp.read_data = r_buf;
                            n_buf         = r_in.vram_read_data;
                        end
                    end
                    default: begin
                        rsp.read_data = r_open_bus;
                    end
                endcase
            end else begin
                unique case (r_in.reg_index)
                    vrp_pkg::REG_CTRL: begin
                        n_ctrl  = r_in.write_value;
                        n_temp  = {r_temp[14:12], r_in.write_value[1:0], r_temp[9:0]};
                        rsp.nmi_request = !r_ctrl[7] && r_in.write_value[7]
                                          && r_in.in_vblank;
                        n_open_bus = r_in.write_value;
                    end
                    vrp_pkg::REG_MASK: begin
                        n_mask     = r_in.write_value;
                        n_open_bus = r_in.write_value;
                    end
                    vrp_pkg::REG_STATUS: begin
                        n_open_bus = r_in.write_value;
                    end
                    vrp_pkg::REG_OAM_ADDR: begin
                        n_attr_addr = r_in.write_value[vrp_pkg::ATTR_AW-1:0];
                        n_open_bus  = r_in.write_value;
                    end
                    vrp_pkg::REG_OAM_DATA: begin
                        attr_req.we = 1'b1;
                        n_attr_addr = r_attr_addr + 1'b1;
                    end
                    vrp_pkg::REG_SCROLL: begin
                        if (r_toggle) begin
                            n_temp = {r_in.write_value[2:0], r_temp[11:10],
                                      r_in.write_value[7:3], r_temp[4:0]};
                        end else begin
                            n_fine_x = r_in.write_value[2:0];
                            n_temp   = {r_temp[14:5], r_in.write_value[7:3]};
                        end
                        n_toggle   = !r_toggle;
                        n_open_bus = r_in.write_value;
                    end
                    vrp_pkg::REG_ADDR: begin
                        if (r_toggle) begin
                            n_temp  = addr_load;
                            n_vaddr = addr_load;
                            if (addr_load < vrp_pkg::PALETTE_BASE) begin
                                n_bus = addr_load;
                            end
                        end else begin
                            n_temp = {1'b0, r_in.write_value[5:0], r_temp[7:0]};
                        end
                        n_toggle   = !r_toggle;
                        n_open_bus = r_in.write_value;
                    end
                    default: begin
                        rsp.vram_address    = r_vaddr;
                        rsp.vram_access     = vrp_pkg::ACC_WRITE;
                        rsp.vram_write_data = r_in.write_value;
                        n_vaddr             = stepped;
                        if (stepped < vrp_pkg::PALETTE_BASE) begin
                            n_bus = stepped;
                        end
                    end
                endcase
            end
        end

        // The registered read always tracks the address the next item will use.
        attr_req.raddr = n_attr_addr;

        rsp.control_value  = n_ctrl;
        rsp.mask_value     = n_mask;
        rsp.scroll_temp    = n_temp;
        rsp.fine_scroll_x  = n_fine_x;
        rsp.render_address = n_bus;
    end

    vrp_attr_store u_attr_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (attr_req),
        .o_rdata (attr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_ctrl      <= '0;
            r_mask      <= '0;
            r_attr_addr <= '0;
            r_temp      <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_vaddr     <= '0;
            r_bus       <= '0;
            r_buf       <= '0;
            r_open_bus  <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (out_free) begin
                r_out_vld <= process;
            end
            r_ctrl      <= n_ctrl;
            r_mask      <= n_mask;
            r_attr_addr <= n_attr_addr;
            r_temp      <= n_temp;
            r_fine_x    <= n_fine_x;
            r_toggle    <= n_toggle;
            r_vaddr     <= n_vaddr;
            r_bus       <= n_bus;
            r_buf       <= n_buf;
            r_open_bus  <= n_open_bus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (process) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    a_no_access_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.vram_access == vrp_pkg::ACC_NONE |-> r_out.vram_address == '0)
        else $error("video address reported without an access");

    a_oam_write_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in.command == vrp_pkg::CMD_WRITE
            && r_in.reg_index == vrp_pkg::REG_OAM_DATA
        |=> r_attr_addr == $past(r_attr_addr) + 1'b1)
        else $error("attribute address did not step after data write");

    a_status_clears_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in.command == vrp_pkg::CMD_READ
            && r_in.reg_index == vrp_pkg::REG_STATUS
        |=> !r_toggle)
        else $error("status read did not clear the write toggle");

    a_nmi_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.nmi_request |-> r_out.control_value[7])
        else $error("NMI request without NMI enable set");

endmodule

// File: rtl/vrp_attr_store.sv
// Object attribute store: 256-byte memory with per-entry valid bits.
`timescale 1ns / 1ps

module vrp_attr_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrp_pkg::t_attr_req  i_req,
    output logic [7:0]          o_rdata
);

    logic [7:0]                    r_mem [vrp_pkg::ATTR_DEPTH];
    logic [vrp_pkg::ATTR_DEPTH-1:0] r_vld;
    logic [7:0]                    r_rdata;
    logic                          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_hit <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_hit ? r_rdata : 8'd0;

    // A write always moves the attribute address on, so no read-during-write.
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.we |-> i_req.raddr != i_req.waddr)
        else $error("attribute read and write address collide");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.we |=> r_vld[$past(i_req.waddr)])
        else $error("written attribute entry not marked valid");

    a_reset_clears_hit: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_hit && r_vld == '0)
        else $error("attribute valid state not cleared by reset");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the video register port: random access stream against a predictor.
`timescale 1ns / 1ps

module tb;
    import vrp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vrp_req_if req_ch ();
    vrp_rsp_if rsp_ch ();

    video_register_port_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register window state as the processor sees it.
    logic [7:0]  ctrl_r;
    logic [7:0]  mask_r;
    logic [7:0]  oam_addr_r;
    logic [7:0]  oam_mem [ATTR_DEPTH];
    logic [14:0] tmp_addr_r;
    logic [2:0]  fine_x_r;
    logic        toggle_r;
    logic [14:0] vaddr_r;
    logic [14:0] bus_addr_r;
    logic [7:0]  rbuf_r;
    logic [7:0]  obus_r;

    t_req access_q [$];
    t_rsp port_result_q [$];
    t_rsp got_rsp;
    t_rsp want_rsp;

    int n_total    = 0;
    int n_issued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    function automatic t_rsp apply_register_access(input t_req r);
        t_rsp        p;
        logic [14:0] incr;
        logic        was_on;
        p = '0;
        incr = ctrl_r[2] ? STEP_ROW : STEP_ONE;
        if (r.command == CMD_READ) begin
            case (r.reg_index)
                REG_STATUS: begin
                    p.read_data   = r.status_byte;
                    p.status_read = 1'b1;
                    toggle_r      = 1'b0;
                end
                REG_OAM_DATA: begin
                    p.read_data = r.oam_clearing ? OAM_CLEARED : oam_mem[oam_addr_r];
                end
                REG_DATA: begin
                    p.vram_address = vaddr_r;
                    p.vram_access  = ACC_READ;
                    vaddr_r        = vaddr_r + incr;
                    bus_addr_r     = vaddr_r;
                    // Palette bytes bypass the delay buffer, which refills from the mirror.
                    if (p.vram_address >= PALETTE_BASE) begin
                        rbuf_r      = r.vram_mirror_data;
                        p.read_data = r.vram_read_data;
                    end else begin
                        p.read_data = rbuf_r;
                        rbuf_r      = r.vram_read_data;
                    end
                end
                default: begin
                    p.read_data = obus_r;
                end
            endcase
        end else begin
            case (r.reg_index)
                REG_CTRL: begin
                    was_on            = ctrl_r[7];
                    ctrl_r            = r.write_value;
                    tmp_addr_r[11:10] = r.write_value[1:0];
                    p.nmi_request     = !was_on && r.write_value[7] && r.in_vblank;
                    obus_r            = r.write_value;
                end
                REG_MASK: begin
                    mask_r = r.write_value;
                    obus_r = r.write_value;
                end
                REG_STATUS: begin
                    obus_r = r.write_value;
                end
                REG_OAM_ADDR: begin
                    oam_addr_r = r.write_value;
                    obus_r     = r.write_value;
                end
                REG_OAM_DATA: begin
                    oam_mem[oam_addr_r] = r.write_value;
                    oam_addr_r          = oam_addr_r + 8'd1;
                end
                REG_SCROLL: begin
                    if (toggle_r) begin
                        tmp_addr_r[9:5]   = r.write_value[7:3];
                        tmp_addr_r[14:12] = r.write_value[2:0];
                    end else begin
                        fine_x_r        = r.write_value[2:0];
                        tmp_addr_r[4:0] = r.write_value[7:3];
                    end
                    toggle_r = !toggle_r;
                    obus_r   = r.write_value;
                end
                REG_ADDR: begin
                    if (toggle_r) begin
                        tmp_addr_r = {1'b0, tmp_addr_r[13:8], r.write_value};
                        vaddr_r    = tmp_addr_r;
                        if (vaddr_r < PALETTE_BASE) bus_addr_r = vaddr_r;
                    end else begin
                        tmp_addr_r = {1'b0, r.write_value[5:0], tmp_addr_r[7:0]};
                    end
                    toggle_r = !toggle_r;
                    obus_r   = r.write_value;
                end
                default: begin
                    p.vram_address    = vaddr_r;
                    p.vram_access     = ACC_WRITE;
                    p.vram_write_data = r.write_value;
                    vaddr_r           = vaddr_r + incr;
                    if (vaddr_r < PALETTE_BASE) bus_addr_r = vaddr_r;
                end
            endcase
        end
        p.control_value  = ctrl_r;
        p.mask_value     = mask_r;
        p.scroll_temp    = tmp_addr_r;
        p.fine_scroll_x  = fine_x_r;
        p.render_address = bus_addr_r;
        return p;
    endfunction

    task automatic add_access(input logic cmd, input logic [2:0] idx, input logic [7:0] val,
                              input logic vbl, input logic clr);
        t_req r;
        r.command          = cmd;
        r.reg_index        = idx;
        r.write_value      = val;
        r.vram_read_data   = 8'($urandom_range(0, 255));
        r.vram_mirror_data = 8'($urandom_range(0, 255));
        r.status_byte      = 8'($urandom_range(0, 255));
        r.in_vblank        = vbl;
        r.oam_clearing     = clr;
        access_q.push_back(r);
    endtask

    task automatic add_rand(input logic cmd, input logic [2:0] idx, input logic [7:0] val);
        add_access(cmd, idx, val, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    endtask

    task automatic report_mismatch(input string msg);
        if (n_errors < 100) $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
    endtask

    // Driver: offers the next pending access once the previous one has transferred.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (access_q.size() > 0 &&
                $urandom_range(0, 99) >= ((n_issued * 3 < n_total) ? 23 :
                                          (n_issued * 3 < 2 * n_total) ? 66 : 0)) begin
                req_ch.data  <= access_q.pop_front();
                req_ch.valid <= 1'b1;
                n_issued++;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: one long stall at the start of the last phase backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (!hold_done && n_issued * 3 >= 2 * n_total) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= $urandom_range(0, 99) >=
                                ((n_issued * 3 < n_total) ? 66 :
                                 (n_issued * 3 < 2 * n_total) ? 23 : 0);
            end
        end
    end

    // Monitor: predicts on each request transfer and checks each result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                port_result_q.push_back(apply_register_access(req_ch.data));
                n_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_rsp = rsp_ch.data;
                if (port_result_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no access pending",
                                              n_results));
                end else begin
                    want_rsp = port_result_q.pop_front();
                    check_field("read_data", int'(got_rsp.read_data),
                                int'(want_rsp.read_data));
                    check_field("vram_access", int'(got_rsp.vram_access),
                                int'(want_rsp.vram_access));
                    check_field("vram_address", int'(got_rsp.vram_address),
                                int'(want_rsp.vram_address));
                    check_field("vram_write_data", int'(got_rsp.vram_write_data),
                                int'(want_rsp.vram_write_data));
                    check_field("nmi_request", int'(got_rsp.nmi_request),
                                int'(want_rsp.nmi_request));
                    check_field("status_read", int'(got_rsp.status_read),
                                int'(want_rsp.status_read));
                    check_field("control_value", int'(got_rsp.control_value),
                                int'(want_rsp.control_value));
                    check_field("mask_value", int'(got_rsp.mask_value),
                                int'(want_rsp.mask_value));
                    check_field("scroll_temp", int'(got_rsp.scroll_temp),
                                int'(want_rsp.scroll_temp));
                    check_field("fine_scroll_x", int'(got_rsp.fine_scroll_x),
                                int'(want_rsp.fine_scroll_x));
                    check_field("render_address", int'(got_rsp.render_address),
                                int'(want_rsp.render_address));
                end
                n_results++;
            end
        end
    end

    initial begin
        int         kind;
        int         n;
        logic [7:0] hi;
        logic [7:0] a;
        bit         wrap_done;

        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        ctrl_r = '0; mask_r = '0; oam_addr_r = '0; tmp_addr_r = '0; fine_x_r = '0;
        toggle_r = 1'b0; vaddr_r = '0; bus_addr_r = '0; rbuf_r = '0; obus_r = '0;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        wrap_done = 1'b0;

        // Directed accesses: open bus, NMI edge, attribute wrap, palette and buffered reads.
        add_access(CMD_READ,  REG_CTRL,     8'h00, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_MASK,     8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_CTRL,     8'h80, 1'b1, 1'b0);
        add_access(CMD_WRITE, REG_CTRL,     8'h84, 1'b1, 1'b0);
        add_access(CMD_WRITE, REG_CTRL,     8'h00, 1'b1, 1'b0);
        add_access(CMD_WRITE, REG_CTRL,     8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_CTRL,     8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_MASK,     8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_STATUS,   8'hA5, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_OAM_ADDR, 8'h00, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_STATUS,   8'h00, 1'b1, 1'b1);
        add_access(CMD_WRITE, REG_OAM_ADDR, 8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_OAM_DATA, 8'h5A, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_OAM_DATA, 8'h00, 1'b0, 1'b1);
        add_access(CMD_READ,  REG_OAM_DATA, 8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_SCROLL,   8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_SCROLL,   8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_ADDR,     8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_ADDR,     8'h00, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_DATA,     8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_DATA,     8'hFF, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_ADDR,     8'h3E, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_ADDR,     8'hFF, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_DATA,     8'h00, 1'b0, 1'b0);
        add_access(CMD_WRITE, REG_DATA,     8'h00, 1'b0, 1'b0);
        add_access(CMD_READ,  REG_SCROLL,   8'h00, 1'b0, 1'b0);

        n = access_q.size() + 1600;
        while (access_q.size() < n) begin
            if (!wrap_done && access_q.size() > 500) begin
                // A long run of data accesses at a 32-byte stride from the palette area
                // walks through the upper half and wraps the address.
                wrap_done = 1'b1;
                add_rand(CMD_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                add_rand(CMD_WRITE, REG_CTRL, 8'($urandom_range(0, 255)) | 8'h04);
                add_rand(CMD_WRITE, REG_ADDR, (8'($urandom_range(0, 255)) & 8'hC0) | 8'h3F);
                add_rand(CMD_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
                repeat (530)
                    add_rand(1'($urandom_range(0, 1)), REG_DATA,
                             8'($urandom_range(0, 255)));
            end else begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0: begin
                        repeat ($urandom_range(1, 4))
                            add_rand(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                     8'($urandom_range(0, 255)));
                    end
                    1, 2: begin
                        if ($urandom_range(0, 3) != 0)
                            add_rand(CMD_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                        hi = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 3) == 0) hi[5:0] = 6'h3F;
                        add_rand(CMD_WRITE, REG_ADDR, hi);
                        add_rand(CMD_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
                        repeat ($urandom_range(1, 8))
                            add_rand(1'($urandom_range(0, 1)), REG_DATA,
                                     8'($urandom_range(0, 255)));
                    end
                    3: begin
                        add_rand(CMD_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
                    end
                    4: begin
                        add_rand(CMD_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                        add_rand(CMD_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                        add_rand(CMD_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                    end
                    5: begin
                        a = 8'($urandom_range(0, 255));
                        add_rand(CMD_WRITE, REG_OAM_ADDR, a);
                        repeat ($urandom_range(1, 6))
                            add_rand(CMD_WRITE, REG_OAM_DATA, 8'($urandom_range(0, 255)));
                        add_rand(CMD_WRITE, REG_OAM_ADDR, a);
                        repeat ($urandom_range(1, 6))
                            add_rand(CMD_READ, REG_OAM_DATA, 8'($urandom_range(0, 255)));
                    end
                    6: begin
                        add_rand(CMD_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
                        add_rand(1'($urandom_range(0, 1)), REG_STATUS,
                                 8'($urandom_range(0, 255)));
                    end
                    7: begin
                        case ($urandom_range(0, 4))
                            0: add_rand(CMD_READ, REG_CTRL, 8'($urandom_range(0, 255)));
                            1: add_rand(CMD_READ, REG_MASK, 8'($urandom_range(0, 255)));
                            2: add_rand(CMD_READ, REG_OAM_ADDR, 8'($urandom_range(0, 255)));
                            3: add_rand(CMD_READ, REG_SCROLL, 8'($urandom_range(0, 255)));
                            default: add_rand(CMD_READ, REG_ADDR, 8'($urandom_range(0, 255)));
                        endcase
                    end
                    8: begin
                        repeat ($urandom_range(1, 12))
                            add_rand(1'($urandom_range(0, 1)), REG_DATA,
                                     8'($urandom_range(0, 255)));
                    end
                    default: begin
                        // A lone toggle write leaves the next pair out of step.
                        add_rand(CMD_WRITE, ($urandom_range(0, 1) != 0) ? REG_SCROLL : REG_ADDR,
                                 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
        n_total = access_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || port_result_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0 && port_result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/vrp_pkg.sv
rtl/vrp_req_if.sv
rtl/vrp_rsp_if.sv
rtl/vrp_attr_store.sv
rtl/video_register_port_core.sv
sim/tb.sv
